// ===== hw/rtl/lfrt_pkg.sv =====
// shared types, codes and defaults for the lockstep fragment receipt tracker
`timescale 1ns / 1ps

package lfrt_pkg;

	localparam int PLAYERS_DEF = 12;
	localparam int SLOTS_DEF   = 4;
	localparam int FRAGS_DEF   = 8;

	// depth of the queue between the front and the back
	localparam int QDEPTH = 2;

	// operations
	localparam logic [1:0] OP_FRAG    = 2'd0;
	localparam logic [1:0] OP_ADVANCE = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// front classification of a fragment
	localparam logic [1:0] CLS_OK     = 2'd0;
	localparam logic [1:0] CLS_DEST   = 2'd1;
	localparam logic [1:0] CLS_PLAYER = 2'd2;

	// result status codes
	localparam logic [3:0] ST_STORED   = 4'd0;
	localparam logic [3:0] ST_COMPLETE = 4'd1;
	localparam logic [3:0] ST_DEST     = 4'd2;
	localparam logic [3:0] ST_PLAYER   = 4'd3;
	localparam logic [3:0] ST_STALE    = 4'd4;
	localparam logic [3:0] ST_WINDOW   = 4'd5;
	localparam logic [3:0] ST_COUNT    = 4'd6;
	localparam logic [3:0] ST_DUP      = 4'd7;
	localparam logic [3:0] ST_TICK_OP  = 4'd8;

	// configuration register indexes
	localparam logic [1:0] REG_STATION = 2'd0;
	localparam logic [1:0] REG_OWN     = 2'd1;
	localparam logic [1:0] REG_ACTIVE  = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  cls;
		logic        bad_total;
		logic [3:0]  player;
		logic [30:0] tick;
		logic [3:0]  total;
		logic [3:0]  frag_index;
	} lfrt_item_t;

endpackage

// ===== hw/rtl/lfrt_front.sv =====
// front: takes a command and classifies it against the configuration
`timescale 1ns / 1ps

module lfrt_front #(
	parameter int PLAYERS = lfrt_pkg::PLAYERS_DEF,
	parameter int FRAGS   = lfrt_pkg::FRAGS_DEF
) (
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         operation,
	input  logic [31:0]        dest_id,
	input  logic [3:0]         player,
	input  logic [30:0]        tick,
	input  logic [3:0]         frag_total,
	input  logic [3:0]         frag_index,
	input  logic [31:0]        station_id,
	output logic               push,
	output lfrt_pkg::lfrt_item_t item
);
	import lfrt_pkg::*;

	assign push = start & ~busy;

	always_comb begin
		item.op         = operation;
		item.player     = player;
		item.tick       = tick;
		item.total      = frag_total;
		item.frag_index = frag_index;
		item.bad_total  = (frag_total == 4'd0) || (frag_total > 4'(FRAGS));
		priority if (dest_id != station_id) begin
			item.cls = CLS_DEST;
		end else if ({1'b0, player} >= 5'(PLAYERS)) begin
			item.cls = CLS_PLAYER;
		end else begin
			item.cls = CLS_OK;
		end
	end

endmodule

// ===== hw/rtl/lfrt_queue.sv =====
// short queue of classified commands between front and back
`timescale 1ns / 1ps

module lfrt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lfrt_pkg::lfrt_item_t item_in,
	input  logic                 pop,
	output logic                 filled,
	output lfrt_pkg::lfrt_item_t head
);
	import lfrt_pkg::*;

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	lfrt_item_t         entry_q [QDEPTH];
	logic [QAW-1:0]     wr_ptr_q;
	logic [QAW-1:0]     rd_ptr_q;
	logic [QAW:0]       count_q;

	assign filled = (count_q != '0);
	assign head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

// ===== hw/rtl/lfrt_back.sv =====
// back: tick ring state, fragment bitmap store and result register
`timescale 1ns / 1ps

module lfrt_back #(
	parameter int PLAYERS = lfrt_pkg::PLAYERS_DEF,
	parameter int SLOTS   = lfrt_pkg::SLOTS_DEF,
	parameter int FRAGS   = lfrt_pkg::FRAGS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_filled,
	input  lfrt_pkg::lfrt_item_t q_head,
	output logic                 pop,
	output logic                 working,
	input  logic [3:0]           own_player,
	input  logic [11:0]          active_players,
	output logic                 result_valid,
	output logic [3:0]           status,
	output logic [3:0]           completed_player,
	output logic [11:0]          current_mask,
	output logic                 all_received,
	output logic [30:0]          current_tick
);
	import lfrt_pkg::*;

	localparam int PW    = $clog2(PLAYERS);
	localparam int SW    = $clog2(SLOTS);
	localparam int FW    = (FRAGS > 1) ? $clog2(FRAGS) : 1;
	localparam int CELLS = SLOTS * PLAYERS;
	localparam int AW    = $clog2(CELLS);
	localparam int EW    = FRAGS + 4;
	localparam int XW    = (PLAYERS > 12) ? PLAYERS : 12;

	// tracker state
	logic [SW-1:0]      cur_q;
	logic [30:0]        base_q;
	logic [30:0]        net_q [PLAYERS];
	logic [PLAYERS-1:0] mask_q [SLOTS];
	logic [PLAYERS-1:0] vld_q [SLOTS];
	logic [EW-1:0]      mem_q [CELLS];

	// stage 1
	logic               v_s1;
	lfrt_item_t         item_s1;
	logic [3:0]         st_s1;
	logic               go_s1;
	logic [SW-1:0]      slot_s1;
	logic [PW-1:0]      pl_s1;
	logic [AW-1:0]      cell_s1;
	logic [EW-1:0]      rd_s1;

	// result register
	logic               rvalid_q;
	logic [3:0]         status_q;
	logic [3:0]         done_q;
	logic [11:0]        mask_out_q;
	logic               all_q;
	logic [30:0]        tick_q;

	// lookup side
	logic [PW-1:0]      pl_a;
	logic [31:0]        diff_a;
	logic               in_win_a;
	logic [SW-1:0]      off_a;
	logic [SW:0]        sum_a;
	logic [SW-1:0]      slot_a;
	logic [AW-1:0]      cell_a;
	logic [3:0]         st_a;
	logic               go_a;

	assign pop     = q_filled & ~v_s1;
	assign working = v_s1;

	always_comb begin
		pl_a     = (q_head.cls == CLS_OK) ? q_head.player[PW-1:0] : '0;
		diff_a   = {1'b0, q_head.tick} - {1'b0, base_q};
		in_win_a = ~diff_a[31] && (diff_a < 32'(SLOTS));
		off_a    = in_win_a ? diff_a[SW-1:0] : '0;
		sum_a    = {1'b0, cur_q} + {1'b0, off_a};
		slot_a   = (sum_a >= (SW+1)'(SLOTS)) ? SW'(sum_a - (SW+1)'(SLOTS)) : sum_a[SW-1:0];
		cell_a   = AW'(slot_a * PLAYERS) + AW'(pl_a);
		go_a     = 1'b0;
		if (q_head.op != OP_FRAG) begin
			st_a = ST_TICK_OP;
		end else begin
			priority if (q_head.cls == CLS_DEST) begin
				st_a = ST_DEST;
			end else if (q_head.cls == CLS_PLAYER) begin
				st_a = ST_PLAYER;
			end else if (q_head.tick < net_q[pl_a]) begin
				st_a = ST_STALE;
			end else if (!in_win_a) begin
				st_a = ST_WINDOW;
			end else if (q_head.bad_total) begin
				st_a = ST_COUNT;
			end else begin
				st_a = ST_STORED;
				go_a = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= q_head;
			st_s1   <= st_a;
			go_s1   <= go_a;
			slot_s1 <= slot_a;
			pl_s1   <= pl_a;
			cell_s1 <= cell_a;
			rd_s1   <= mem_q[cell_a];
		end
	end

	// bitmap update side
	logic               inprog_b;
	logic [3:0]         cnt_b;
	logic [FRAGS-1:0]   bm_b;
	logic [FRAGS-1:0]   bit_b;
	logic [FRAGS-1:0]   full_b;
	logic [FRAGS-1:0]   bm_new_b;
	logic               bad_cnt_b;
	logic               dup_b;
	logic               fin_b;
	logic               wr_b;
	logic [3:0]         st_b;
	logic [PLAYERS-1:0] own_bit;
	logic [PLAYERS-1:0] pl_bit;
	logic [SW-1:0]      cur_next;
	logic [30:0]        base_next;
	logic [PLAYERS-1:0] mask_next;
	logic [XW-1:0]      mask_ext;

	always_comb begin
		inprog_b = vld_q[slot_s1][pl_s1];
		cnt_b    = inprog_b ? rd_s1[EW-1:FRAGS] : item_s1.total;
		bm_b     = inprog_b ? rd_s1[FRAGS-1:0] : '0;
		bit_b    = '0;
		bit_b[item_s1.frag_index[FW-1:0]] = 1'b1;
		for (int i = 0; i < FRAGS; i++) begin
			full_b[i] = (4'(i) < cnt_b);
		end
		bm_new_b  = bm_b | bit_b;
		bad_cnt_b = (item_s1.total > cnt_b) || (item_s1.frag_index >= cnt_b);
		dup_b     = |(bm_b & bit_b);
		fin_b     = go_s1 && !bad_cnt_b && !dup_b && ((bm_new_b & full_b) == full_b);
		// a fresh count is kept even when its first fragment is rejected
		wr_b      = go_s1 && !fin_b && (!inprog_b || (!bad_cnt_b && !dup_b));
		priority if (!go_s1) begin
			st_b = st_s1;
		end else if (bad_cnt_b) begin
			st_b = ST_COUNT;
		end else if (dup_b) begin
			st_b = ST_DUP;
		end else if (fin_b) begin
			st_b = ST_COMPLETE;
		end else begin
			st_b = ST_STORED;
		end
		for (int i = 0; i < PLAYERS; i++) begin
			own_bit[i] = (own_player == 4'(i));
			pl_bit[i]  = (pl_s1 == PW'(i));
		end
	end

	always_comb begin
		cur_next  = cur_q;
		base_next = base_q;
		mask_next = mask_q[cur_q];
		unique case (item_s1.op)
			OP_ADVANCE: begin
				cur_next  = (cur_q == SW'(SLOTS - 1)) ? '0 : cur_q + 1'b1;
				base_next = base_q + 31'd1;
				mask_next = own_bit;
			end
			OP_RESTART: begin
				base_next = item_s1.tick;
				mask_next = own_bit;
			end
			OP_FRAG: begin
				if (fin_b && (slot_s1 == cur_q)) begin
					mask_next = mask_q[cur_q] | pl_bit;
				end
			end
			default: begin
				mask_next = mask_q[cur_q];
			end
		endcase
		mask_ext = XW'(mask_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			base_q   <= '0;
			rvalid_q <= 1'b0;
			for (int p = 0; p < PLAYERS; p++) begin
				net_q[p] <= '0;
			end
			for (int s = 0; s < SLOTS; s++) begin
				mask_q[s] <= PLAYERS'(1);
				vld_q[s]  <= '0;
			end
		end else begin
			rvalid_q <= v_s1;
			if (v_s1) begin
				cur_q  <= cur_next;
				base_q <= base_next;
				unique case (item_s1.op)
					OP_ADVANCE: begin
						mask_q[cur_next] <= own_bit;
						vld_q[cur_next]  <= '0;
					end
					OP_RESTART: begin
						for (int p = 0; p < PLAYERS; p++) begin
							net_q[p] <= item_s1.tick;
						end
						for (int s = 0; s < SLOTS; s++) begin
							mask_q[s] <= own_bit;
							vld_q[s]  <= '0;
						end
					end
					OP_FRAG: begin
						if (fin_b) begin
							vld_q[slot_s1][pl_s1] <= 1'b0;
							net_q[pl_s1]          <= net_q[pl_s1] + 31'd1;
							mask_q[slot_s1]       <= mask_q[slot_s1] | pl_bit;
						end else if (wr_b) begin
							vld_q[slot_s1][pl_s1] <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && wr_b) begin
			mem_q[cell_s1] <= {cnt_b, (bad_cnt_b || dup_b) ? bm_b : bm_new_b};
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			status_q   <= st_b;
			done_q     <= fin_b ? item_s1.player : 4'd0;
			mask_out_q <= mask_ext[11:0];
			all_q      <= (mask_ext[11:0] == active_players);
			tick_q     <= base_next;
		end
	end

	assign result_valid     = rvalid_q;
	assign status           = status_q;
	assign completed_player = done_q;
	assign current_mask     = mask_out_q;
	assign all_received     = all_q;
	assign current_tick     = tick_q;

	// one transaction in the back at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> !v_s1)
		else $error("back took a second transaction while busy");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> rvalid_q)
		else $error("no result after a transaction in the back");

	a_done_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(rvalid_q && (status_q != ST_COMPLETE)) |-> (done_q == 4'd0))
		else $error("completed player reported without completion");

	a_restart_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (item_s1.op == OP_RESTART)) |=> (tick_q == $past(item_s1.tick)))
		else $error("restart did not load the tick base");

endmodule

// ===== hw/rtl/lockstep_fragment_receipt_tracker.sv =====
// top level of the lockstep fragment receipt tracker
`timescale 1ns / 1ps

// Tracks which fragments of each player's per-tick update have arrived over
// a ring of SLOTS tick slots.
// Command channel: a command is taken at a clock edge where start is high and
// busy is low; operation selects fragment arrival, advance or restart.
// Every command gives exactly one result, shown for one cycle while
// result_valid is high; the receiver cannot stall it.
// A command passes from the queue through the stage 1 registers into the result
// register, which drives result_valid.
// busy stays high while a command waits in the queue or reads the fragment store
// (registered read, then read-modify-write of one store entry), so a new command
// is taken only once the last one has left the back.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready is always high;
// index 0 station id, 1 own player, 2 active players mask. Write only while
// no command is in flight.
// Reset: configuration clears, every slot is empty, the slot masks hold bit 0,
// the tick base and expected ticks are 0. No clearing pass is needed.

module lockstep_fragment_receipt_tracker #(
	parameter int PLAYERS = lfrt_pkg::PLAYERS_DEF,
	parameter int SLOTS   = lfrt_pkg::SLOTS_DEF,
	parameter int FRAGS   = lfrt_pkg::FRAGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] dest_id,
	input  logic [3:0]  player,
	input  logic [30:0] tick,
	input  logic [3:0]  frag_total,
	input  logic [3:0]  frag_index,
	output logic        result_valid,
	output logic [3:0]  status,
	output logic [3:0]  completed_player,
	output logic [11:0] current_mask,
	output logic        all_received,
	output logic [30:0] current_tick,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import lfrt_pkg::*;

	logic [31:0] station_id_q;
	logic [3:0]  own_player_q;
	logic [11:0] active_q;

	logic        push;
	lfrt_item_t  item;
	logic        q_filled;
	lfrt_item_t  q_head;
	logic        pop;
	logic        working;

	assign cfg_ready = 1'b1;
	assign busy      = q_filled | working;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_id_q <= '0;
			own_player_q <= '0;
			active_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STATION: station_id_q <= cfg_data;
				REG_OWN:     own_player_q <= cfg_data[3:0];
				REG_ACTIVE:  active_q     <= cfg_data[11:0];
				default:     active_q     <= active_q;
			endcase
		end
	end

	lfrt_front #(
		.PLAYERS (PLAYERS),
		.FRAGS   (FRAGS)
	) u_front (
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.dest_id    (dest_id),
		.player     (player),
		.tick       (tick),
		.frag_total (frag_total),
		.frag_index (frag_index),
		.station_id (station_id_q),
		.push       (push),
		.item       (item)
	);

	lfrt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item_in (item),
		.pop     (pop),
		.filled  (q_filled),
		.head    (q_head)
	);

	lfrt_back #(
		.PLAYERS (PLAYERS),
		.SLOTS   (SLOTS),
		.FRAGS   (FRAGS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_filled         (q_filled),
		.q_head           (q_head),
		.pop              (pop),
		.working          (working),
		.own_player       (own_player_q),
		.active_players   (active_q),
		.result_valid     (result_valid),
		.status           (status),
		.completed_player (completed_player),
		.current_mask     (current_mask),
		.all_received     (all_received),
		.current_tick     (current_tick)
	);

endmodule
